// ===== hw/rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD card SPI-mode entry sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    // Event kinds carried on the input channel.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    // Sequencer phases.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PREAMBLE = 3'd1;
    localparam logic [2:0] PH_BUSY     = 3'd2;
    localparam logic [2:0] PH_CMD      = 3'd3;
    localparam logic [2:0] PH_POLL     = 3'd4;
    localparam logic [2:0] PH_DONE     = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INIT_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_BUSY_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_PREAMBLE     = 2'd2;

    localparam int CFG_TIMEOUT_W = 24;

    // Register values after reset (2000 * 48, 300 * 48 and 10).
    localparam logic [CFG_TIMEOUT_W-1:0] INIT_TIMEOUT_RST = 24'd96000;
    localparam logic [CFG_TIMEOUT_W-1:0] BUSY_TIMEOUT_RST = 24'd14400;
    localparam logic [3:0]               PREAMBLE_RST     = 4'd10;

    // Bytes on the wire.
    localparam logic [7:0] BYTE_IDLE      = 8'hFF;
    localparam logic [7:0] R1_IDLE_STATE  = 8'h01;
    localparam logic [3:0] CMD0_LEN       = 4'd6;

    typedef struct packed {
        logic [CFG_TIMEOUT_W-1:0] init_timeout_ticks;
        logic [CFG_TIMEOUT_W-1:0] busy_timeout_ticks;
        logic [3:0]               preamble_bytes;
    } cfg_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] byte_count;
        logic [7:0] poll_count;
    } ctl_t;

    typedef struct packed {
        logic       success;
        logic       done_res;
        logic       chip_select;
        logic [7:0] tx_byte;
        logic       send_byte;
    } res_t;

    // CMD0 (GO_IDLE_STATE) frame: 40 00 00 00 00 95.
    function automatic logic [7:0] cmd0_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h40;
            3'd5:    b = 8'h95;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/sdspi_step.sv =====
// ----------------------------------------------------------------------------
// sdspi_step
// Next-state and result logic for one event of the SPI-mode entry sequencer.
// ----------------------------------------------------------------------------
module sdspi_step #(
    parameter int TIMER_WIDTH = 24,
    parameter int POLL_LIMIT  = 255
) (
    input  logic [1:0]             op,
    input  logic [7:0]             rx_byte,
    input  sdspi_pkg::cfg_t        cfg,
    input  sdspi_pkg::ctl_t        ctl,
    input  logic [TIMER_WIDTH-1:0] overall_elapsed,
    input  logic [TIMER_WIDTH-1:0] busy_elapsed,
    output sdspi_pkg::ctl_t        ctl_next,
    output logic [TIMER_WIDTH-1:0] overall_next,
    output logic [TIMER_WIDTH-1:0] busy_next,
    output logic                   res_valid,
    output sdspi_pkg::res_t        res
);
    import sdspi_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > CFG_TIMEOUT_W) ? TIMER_WIDTH : CFG_TIMEOUT_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
    localparam logic [7:0] POLL_MAX = 8'(POLL_LIMIT);

    logic active;
    logic retry;
    logic deadline_ok;
    logic busy_ok;

    assign active      = (ctl.phase != PH_IDLE) && (ctl.phase != PH_DONE);
    assign deadline_ok = CMP_W'(overall_elapsed) <= CMP_W'(cfg.init_timeout_ticks);
    assign busy_ok     = CMP_W'(busy_elapsed) < CMP_W'(cfg.busy_timeout_ticks);

    always_comb begin
        ctl_next     = ctl;
        overall_next = overall_elapsed;
        busy_next    = busy_elapsed;
        res_valid    = 1'b0;
        res          = '0;
        retry        = 1'b0;

        unique case (op)
            OP_START: begin
                overall_next        = '0;
                busy_next           = '0;
                ctl_next.poll_count = '0;
                ctl_next.byte_count = '0;
                res_valid           = 1'b1;
                if (cfg.preamble_bytes != 4'd0) begin
                    ctl_next.phase      = PH_PREAMBLE;
                    ctl_next.byte_count = 4'd1;
                    res.send_byte       = 1'b1;
                    res.tx_byte         = BYTE_IDLE;
                end else begin
                    // Elapsed was just cleared, so the deadline always holds.
                    ctl_next.phase  = PH_BUSY;
                    res.send_byte   = 1'b1;
                    res.tx_byte     = BYTE_IDLE;
                    res.chip_select = 1'b1;
                end
            end
            OP_TICK: begin
                // Saturating tick counters, running only while active.
                if (active) begin
                    if (overall_elapsed != TIMER_MAX) begin
                        overall_next = overall_elapsed + 1'b1;
                    end
                    if (busy_elapsed != TIMER_MAX) begin
                        busy_next = busy_elapsed + 1'b1;
                    end
                end
            end
            OP_RX: begin
                if (active) begin
                    res_valid = 1'b1;
                    unique case (ctl.phase)
                        PH_PREAMBLE: begin
                            if (ctl.byte_count < cfg.preamble_bytes) begin
                                ctl_next.byte_count = ctl.byte_count + 4'd1;
                                res.send_byte       = 1'b1;
                                res.tx_byte         = BYTE_IDLE;
                            end else begin
                                retry = 1'b1;
                            end
                        end
                        PH_BUSY: begin
                            if (rx_byte == BYTE_IDLE) begin
                                ctl_next.phase      = PH_CMD;
                                ctl_next.byte_count = 4'd1;
                                res.send_byte       = 1'b1;
                                res.tx_byte         = cmd0_byte(3'd0);
                                res.chip_select     = 1'b1;
                            end else if (busy_ok) begin
                                res.send_byte   = 1'b1;
                                res.tx_byte     = BYTE_IDLE;
                                res.chip_select = 1'b1;
                            end else begin
                                retry = 1'b1;
                            end
                        end
                        PH_CMD: begin
                            res.send_byte   = 1'b1;
                            res.chip_select = 1'b1;
                            if (ctl.byte_count < CMD0_LEN) begin
                                ctl_next.byte_count = ctl.byte_count + 4'd1;
                                res.tx_byte         = cmd0_byte(ctl.byte_count[2:0]);
                            end else begin
                                ctl_next.phase      = PH_POLL;
                                ctl_next.poll_count = '0;
                                res.tx_byte         = BYTE_IDLE;
                            end
                        end
                        PH_POLL: begin
                            if (rx_byte[7] && (ctl.poll_count < POLL_MAX)) begin
                                ctl_next.poll_count = ctl.poll_count + 8'd1;
                                res.send_byte       = 1'b1;
                                res.tx_byte         = BYTE_IDLE;
                                res.chip_select     = 1'b1;
                            end else if (rx_byte == R1_IDLE_STATE) begin
                                ctl_next.phase = PH_DONE;
                                res.done_res   = 1'b1;
                                res.success    = 1'b1;
                            end else begin
                                retry = 1'b1;
                            end
                        end
                        default: begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                // Unused event code: no effect.
            end
        endcase

        // Retry: restart the busy wait if the overall deadline holds.
        if (retry) begin
            if (deadline_ok) begin
                ctl_next.phase  = PH_BUSY;
                busy_next       = '0;
                res.send_byte   = 1'b1;
                res.tx_byte     = BYTE_IDLE;
                res.chip_select = 1'b1;
            end else begin
                ctl_next.phase = PH_DONE;
                res.done_res   = 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/sd_spi_mode_entry_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// sd_spi_mode_entry_sequencer_core
// An event waits in the input register; its result is held in the output register.
// Throughput: one event per cycle unless m_ stalls; the single sequencer step sets the rate.
// A stalled result is held in the output register while a new event is taken.
// Reset (aresetn low, synchronous) idles the sequencer and restores the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
module sd_spi_mode_entry_sequencer_core #(
    parameter int TIMER_WIDTH = 24,
    parameter int POLL_LIMIT  = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Event channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tx_byte
    output logic [3:0]  m_tuser,   // [0] send_byte, [1] chip_select, [2] done_res, [3] success
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import sdspi_pkg::*;

    logic                   in_valid_reg;
    logic [1:0]             in_op_reg;
    logic [7:0]             in_rx_reg;
    cfg_t                   cfg_reg;
    ctl_t                   ctl_reg;
    ctl_t                   ctl_next;
    logic [TIMER_WIDTH-1:0] overall_reg;
    logic [TIMER_WIDTH-1:0] overall_next;
    logic [TIMER_WIDTH-1:0] busy_reg;
    logic [TIMER_WIDTH-1:0] busy_next;
    logic                   res_valid;
    res_t                   res;
    logic                   out_valid_reg;
    res_t                   out_reg;
    logic                   step_en;

    // The held event is stepped when the output register can take its result.
    assign step_en   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_en;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg <= s_tuser;
            in_rx_reg <= s_tdata;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.init_timeout_ticks <= INIT_TIMEOUT_RST;
            cfg_reg.busy_timeout_ticks <= BUSY_TIMEOUT_RST;
            cfg_reg.preamble_bytes     <= PREAMBLE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INIT_TIMEOUT: cfg_reg.init_timeout_ticks <= cfg_data;
                CFG_BUSY_TIMEOUT: cfg_reg.busy_timeout_ticks <= cfg_data;
                CFG_PREAMBLE:     cfg_reg.preamble_bytes     <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    sdspi_step #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .POLL_LIMIT  (POLL_LIMIT)
    ) u_step (
        .op              (in_op_reg),
        .rx_byte         (in_rx_reg),
        .cfg             (cfg_reg),
        .ctl             (ctl_reg),
        .overall_elapsed (overall_reg),
        .busy_elapsed    (busy_reg),
        .ctl_next        (ctl_next),
        .overall_next    (overall_next),
        .busy_next       (busy_next),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.phase      <= PH_IDLE;
            ctl_reg.byte_count <= '0;
            ctl_reg.poll_count <= '0;
            overall_reg        <= '0;
            busy_reg           <= '0;
        end else if (step_en) begin
            ctl_reg     <= ctl_next;
            overall_reg <= overall_next;
            busy_reg    <= busy_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.tx_byte;
    assign m_tuser  = {out_reg.success, out_reg.done_res, out_reg.chip_select,
                       out_reg.send_byte};

endmodule
